FILE: sv/vpf_pkg.sv
// Package: shared types and fixed-point helpers for the velocity penalty force unit.
`default_nettype none
package vpf_pkg;
	localparam int IW = 64;
	typedef logic signed [IW-1:0] q64_t;
	localparam q64_t Q_MAX = {1'b0, {(IW-1){1'b1}}};
	localparam q64_t Q_MIN = {1'b1, {(IW-1){1'b0}}};

	// what the front hands the back
	typedef struct packed {
		q64_t [2:0] n;
		q64_t [2:0] rel;
		logic       quad;
	} vpf_job_t;

	function automatic q64_t sat_add(input q64_t a, input q64_t b);
		logic signed [IW:0] s;
		s = {a[IW-1], a} + {b[IW-1], b};
		if (s[IW] != s[IW-1]) return s[IW] ? Q_MIN : Q_MAX;
		return s[IW-1:0];
	endfunction

	function automatic q64_t sat_sub(input q64_t a, input q64_t b);
		logic signed [IW:0] s;
		s = {a[IW-1], a} - {b[IW-1], b};
		if (s[IW] != s[IW-1]) return s[IW] ? Q_MIN : Q_MAX;
		return s[IW-1:0];
	endfunction

	function automatic q64_t sat_neg(input q64_t a);
		return (a == Q_MIN) ? Q_MAX : -a;
	endfunction

	function automatic logic [IW-1:0] mag(input q64_t a);
		return a[IW-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic q64_t from_mag(input logic neg, input logic [IW-1:0] m);
		if (neg) return m[IW-1] ? Q_MIN : -$signed(m);
		return m[IW-1] ? Q_MAX : $signed(m);
	endfunction
endpackage
`default_nettype wire

FILE: sv/vpf_if.sv
// Interfaces: input and result channels of the velocity penalty force unit.
`default_nettype none
interface vpf_in_if #(parameter int DATA_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] vel_x, vel_y, vel_z;
	logic signed [DATA_WIDTH-1:0] normal_x, normal_y, normal_z;
	logic signed [DATA_WIDTH-1:0] base_x, base_y, base_z;
	modport source (output valid, vel_x, vel_y, vel_z, normal_x, normal_y, normal_z,
		base_x, base_y, base_z, input ready);
	modport sink (input valid, vel_x, vel_y, vel_z, normal_x, normal_y, normal_z,
		base_x, base_y, base_z, output ready);
endinterface

interface vpf_out_if #(parameter int DATA_WIDTH = 32);
	logic valid;
	logic ready;
	logic [1:0] row;
	logic signed [DATA_WIDTH-1:0] force_res, jac_col0, jac_col1, jac_col2;
	logic ok;
	logic last;
	modport source (output valid, row, force_res, jac_col0, jac_col1, jac_col2, ok, last,
		input ready);
	modport sink (input valid, row, force_res, jac_col0, jac_col1, jac_col2, ok, last,
		output ready);
endinterface
`default_nettype wire

FILE: sv/vpf_mul.sv
// Multi-cycle signed Q multiply with rounding and 64-bit saturation (32x32 partials).
`default_nettype none
module vpf_mul #(
	parameter int FRAC_BITS = 16
) (
	input  wire  logic           clk,
	input  wire  logic           arst_n,
	input  wire  logic           start,
	input  wire  vpf_pkg::q64_t  a,
	input  wire  vpf_pkg::q64_t  b,
	output logic                 done,
	output vpf_pkg::q64_t        y
);
	import vpf_pkg::*;
	logic [63:0] am_q, bm_q;
	logic        neg_q;
	logic [127:0] acc_q;
	logic [2:0]  step_q;
	logic        busy_q;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [127:0] sh, rnd;
	logic [63:0] m;

	always_comb begin
		pa = step_q[1] ? am_q[63:32] : am_q[31:0];
		pb = step_q[0] ? bm_q[63:32] : bm_q[31:0];
		pp = {32'd0, pa} * {32'd0, pb};
		sh = {64'd0, pp} << (7'(step_q[1]) * 7'd32 + 7'(step_q[0]) * 7'd32);
		rnd = acc_q + (128'd1 << (FRAC_BITS - 1));
		m = (|(rnd[127:64] >> FRAC_BITS)) ? '1 : 64'(rnd >> FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				am_q <= mag(a);
				bm_q <= mag(b);
				neg_q <= a[63] ^ b[63];
				acc_q <= '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (step_q == 3'd4) begin
					y <= from_mag(neg_q, m);
					done <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					acc_q <= acc_q + sh;
					step_q <= step_q + 3'd1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: sv/vpf_sqrt.sv
// Bit-serial floor square root of a 128-bit value, clamped to the 63-bit range.
`default_nettype none
module vpf_sqrt (
	input  wire  logic          clk,
	input  wire  logic          arst_n,
	input  wire  logic          start,
	input  wire  logic [127:0]  x,
	output logic                done,
	output vpf_pkg::q64_t       y
);
	import vpf_pkg::*;
	logic [127:0] x_q, rem_q, trial;
	logic [63:0]  r_q;
	logic [6:0]   k_q;
	logic         busy_q;

	// restoring digit method: two bits of radicand per step
	always_comb trial = {rem_q[125:0], x_q[127:126]} - {62'd0, r_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			k_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				x_q <= x;
				rem_q <= '0;
				r_q <= '0;
				k_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				x_q <= x_q << 2;
				if (!trial[127]) begin
					rem_q <= trial;
					r_q <= {r_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[125:0], x_q[127:126]};
					r_q <= {r_q[62:0], 1'b0};
				end
				k_q <= k_q + 7'd1;
				if (k_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_comb y = r_q[63] ? Q_MAX : $signed(r_q);
endmodule
`default_nettype wire

FILE: sv/vpf_div.sv
// Bit-serial Q divide a*2^F/d on magnitudes, rounded half away, saturated.
`default_nettype none
module vpf_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire  logic          clk,
	input  wire  logic          arst_n,
	input  wire  logic          start,
	input  wire  vpf_pkg::q64_t a,
	input  wire  vpf_pkg::q64_t d,
	output logic                done,
	output vpf_pkg::q64_t       y
);
	import vpf_pkg::*;
	logic [127:0] num_q;
	logic [64:0]  rem_q, rs;
	logic [63:0]  q_q, d_q;
	logic         ovf_q, neg_q, busy_q, ge;
	logic [7:0]   i_q;
	logic [64:0]  dm;
	logic [63:0]  qf;
	logic         of;

	always_comb begin
		rs = {rem_q[63:0], num_q[127]};
		ge = rs >= {1'b0, d_q};
		dm = {1'b0, d_q} - rem_q;
		of = ovf_q;
		qf = q_q;
		if (rem_q >= dm) begin
			if (&q_q) of = 1'b1;
			else qf = q_q + 64'd1;
		end
		if (of) qf = '1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				num_q <= {64'd0, mag(a)} << FRAC_BITS;
				d_q <= mag(d);
				neg_q <= a[63];
				rem_q <= '0;
				q_q <= '0;
				ovf_q <= 1'b0;
				i_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (i_q == 8'd128) begin
					y <= from_mag(neg_q, qf);
					done <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					num_q <= num_q << 1;
					rem_q <= ge ? rs - {1'b0, d_q} : rs;
					q_q <= {q_q[62:0], ge & ~i_q[7] & (i_q >= 8'd64)};
					if (ge && i_q < 8'd64) ovf_q <= 1'b1;
					i_q <= i_q + 8'd1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: sv/vpf_front.sv
// Front end: accepts beats, forms rel and widened normal, queues jobs for the back end.
`default_nettype none
module vpf_front #(
	parameter int DATA_WIDTH = 32
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	vpf_in_if.sink            in_ch,
	input  wire  logic        quad,
	output logic              job_valid,
	input  wire  logic        job_pop,
	output vpf_pkg::vpf_job_t job
);
	import vpf_pkg::*;
	localparam int DEPTH = 2;
	vpf_job_t   fifo_q [DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	vpf_job_t   nj;

	function automatic q64_t sx(input logic signed [DATA_WIDTH-1:0] v);
		return q64_t'(v);
	endfunction

	always_comb begin
		nj.n[0] = sx(in_ch.normal_x);
		nj.n[1] = sx(in_ch.normal_y);
		nj.n[2] = sx(in_ch.normal_z);
		nj.rel[0] = sat_sub(sx(in_ch.vel_x), sx(in_ch.base_x));
		nj.rel[1] = sat_sub(sx(in_ch.vel_y), sx(in_ch.base_y));
		nj.rel[2] = sat_sub(sx(in_ch.vel_z), sx(in_ch.base_z));
		nj.quad = quad;
	end

	assign in_ch.ready = cnt_q != 2'(DEPTH);
	assign job_valid = cnt_q != 2'd0;
	assign job = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) fifo_q[wp_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) wp_q <= ~wp_q;
			if (job_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_ch.valid && in_ch.ready) - 2'(job_pop);
		end
	end
endmodule
`default_nettype wire

FILE: sv/vpf_back.sv
// Back end: sequencer over shared multiply, divide and root units; emits three rows, or one for a zero normal.
`default_nettype none
module vpf_back #(
	parameter int FRAC_BITS  = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire  logic              clk,
	input  wire  logic              arst_n,
	input  wire  logic              job_valid,
	output logic                    job_pop,
	input  wire  vpf_pkg::vpf_job_t job,
	vpf_out_if.source               out_ch
);
	import vpf_pkg::*;
	typedef enum logic [3:0] {
		S_IDLE, S_NSQ, S_NRT, S_DOT, S_UDIV, S_FJ, S_RSQ, S_RRT, S_RDIV,
		S_QJ, S_EMIT
	} st_t;
	st_t st_q;
	vpf_job_t jb_q;
	q64_t m_q, s_q, r_q;
	q64_t [2:0] u_q, f_q, ru_q;
	q64_t [8:0] jac_q;
	logic [127:0] sq_q;
	logic [3:0] k_q;
	logic       zero_q;
	logic [1:0] row_q;
	// correction term pass uses the multiplier too; tracked by cor_q
	logic cor_q;
	q64_t [2:0] f0_q;

	logic mst, mdn, dst, ddn, rst_s, rdn;
	q64_t ma, mb, my, da, dd, dy, ry;
	logic [127:0] rx;
	logic [63:0]  mg;
	logic [127:0] prod;
	logic [3:0]   fj_ij, cor_ij;
	logic [3:0]   jrow_base;

	vpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (.clk, .arst_n, .start(mst), .a(ma), .b(mb),
		.done(mdn), .y(my));
	vpf_div #(.FRAC_BITS(FRAC_BITS)) u_div (.clk, .arst_n, .start(dst), .a(da), .d(dd),
		.done(ddn), .y(dy));
	vpf_sqrt u_sqrt (.clk, .arst_n, .start(rst_s), .x(rx), .done(rdn), .y(ry));

	function automatic logic signed [DATA_WIDTH-1:0] pk(input q64_t x);
		q64_t hi, lo;
		hi = q64_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
		lo = -hi - 1;
		if (x > hi) return hi[DATA_WIDTH-1:0];
		if (x < lo) return lo[DATA_WIDTH-1:0];
		return x[DATA_WIDTH-1:0];
	endfunction

	// row and column of a flat 3x3 index, as {i, j}
	function automatic logic [3:0] split3(input logic [3:0] k);
		case (k)
			4'd0: return 4'b00_00;
			4'd1: return 4'b00_01;
			4'd2: return 4'b00_10;
			4'd3: return 4'b01_00;
			4'd4: return 4'b01_01;
			4'd5: return 4'b01_10;
			4'd6: return 4'b10_00;
			4'd7: return 4'b10_01;
			4'd8: return 4'b10_10;
			default: return 4'b00_00;
		endcase
	endfunction

	// squares accumulate one component at a time through a dedicated 32x32 product, so
	// the shared multi-cycle unit is avoided: each square is summed from its 32-bit halves
	logic [1:0] hs_q;
	logic [31:0] ha, hb;
	logic [63:0] hp;
	always_comb begin
		mg = mag((st_q == S_NSQ) ? jb_q.n[k_q[1:0]] : jb_q.rel[k_q[1:0]]);
		ha = hs_q[1] ? mg[63:32] : mg[31:0];
		hb = hs_q[0] ? mg[63:32] : mg[31:0];
		hp = {32'd0, ha} * {32'd0, hb};
		prod = {64'd0, hp} << (7'(hs_q[1]) * 7'd32 + 7'(hs_q[0]) * 7'd32);
		rx = sq_q;
	end

	// first Jacobian entry of the row being emitted
	assign jrow_base = {2'd0, row_q} + {1'b0, row_q, 1'b0};

	// operand selection for the shared multiplier and the divider
	always_comb begin
		fj_ij = split3(k_q - 4'd3);
		cor_ij = split3(k_q);
		ma = '0; mb = '0; da = '0; dd = m_q;
		case (st_q)
			S_DOT: begin ma = jb_q.rel[k_q[1:0]]; mb = jb_q.n[k_q[1:0]]; end
			S_FJ: begin
				if (k_q < 4'd3) begin ma = s_q; mb = u_q[k_q[1:0]]; end
				else begin
					ma = jb_q.n[fj_ij[1:0]];
					mb = u_q[fj_ij[3:2]];
				end
			end
			S_QJ: begin
				// correction operands: F(i) unscaled times ru(j)
				if (cor_q) begin ma = f_q[cor_ij[3:2]]; mb = ru_q[cor_ij[1:0]]; end
				else if (k_q < 4'd9) begin ma = jac_q[k_q]; mb = r_q; end
				else if (k_q < 4'd12) begin ma = f_q[2'(k_q - 4'd9)]; mb = r_q; end
				else begin ma = '0; mb = '0; end
			end
			default: ;
		endcase
		if (st_q == S_UDIV) da = jb_q.n[k_q[1:0]];
		if (st_q == S_RDIV) begin da = jb_q.rel[k_q[1:0]]; dd = r_q; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			job_pop <= 1'b0;
			out_ch.valid <= 1'b0;
			mst <= 1'b0; dst <= 1'b0; rst_s <= 1'b0;
		end else begin
			job_pop <= 1'b0;
			mst <= 1'b0; dst <= 1'b0; rst_s <= 1'b0;
			if (out_ch.valid && out_ch.ready && st_q != S_EMIT) out_ch.valid <= 1'b0;
			case (st_q)
				S_IDLE: if (job_valid && !job_pop) begin
					jb_q <= job;
					job_pop <= 1'b1;
					sq_q <= '0; k_q <= '0; hs_q <= '0;
					st_q <= S_NSQ;
				end
				S_NSQ, S_RSQ: begin
					sq_q <= sq_q + prod;
					hs_q <= hs_q + 2'd1;
					if (hs_q == 2'd3) begin
						k_q <= k_q + 4'd1;
						if (k_q == 4'd2) begin
							rst_s <= 1'b1;
							st_q <= (st_q == S_NSQ) ? S_NRT : S_RRT;
						end
					end
				end
				S_NRT: if (rdn) begin
					m_q <= ry;
					k_q <= '0;
					s_q <= '0;
					if (ry == '0) begin
						zero_q <= 1'b1;
						row_q <= '0;
						st_q <= S_EMIT;
					end else begin
						zero_q <= 1'b0;
						mst <= 1'b1;
						st_q <= S_DOT;
					end
				end
				S_DOT: if (mdn) begin
					s_q <= sat_add(s_q, my);
					if (k_q == 4'd2) begin
						k_q <= '0;
						dst <= 1'b1;
						st_q <= S_UDIV;
					end else begin
						k_q <= k_q + 4'd1;
						mst <= 1'b1;
					end
				end
				S_UDIV: if (ddn) begin
					u_q[k_q[1:0]] <= dy;
					if (k_q == 4'd2) begin
						k_q <= '0;
						mst <= 1'b1;
						st_q <= S_FJ;
					end else begin
						k_q <= k_q + 4'd1;
						dst <= 1'b1;
					end
				end
				S_FJ: if (mdn) begin
					if (k_q < 4'd3) f_q[k_q[1:0]] <= sat_neg(my);
					else jac_q[k_q - 4'd3] <= sat_neg(my);
					if (k_q == 4'd11) begin
						k_q <= '0;
						row_q <= '0;
						if (jb_q.quad) begin
							sq_q <= '0; hs_q <= '0;
							st_q <= S_RSQ;
						end else st_q <= S_EMIT;
					end else begin
						k_q <= k_q + 4'd1;
						mst <= 1'b1;
					end
				end
				S_RRT: if (rdn) begin
					r_q <= ry;
					k_q <= '0;
					if (ry == '0) begin
						ru_q <= '0;
						mst <= 1'b1;
						cor_q <= 1'b0;
						st_q <= S_QJ;
					end else begin
						dst <= 1'b1;
						st_q <= S_RDIV;
					end
				end
				S_RDIV: if (ddn) begin
					ru_q[k_q[1:0]] <= dy;
					if (k_q == 4'd2) begin
						k_q <= '0;
						mst <= 1'b1;
						cor_q <= 1'b0;
						st_q <= S_QJ;
					end else begin
						k_q <= k_q + 4'd1;
						dst <= 1'b1;
					end
				end
				S_QJ: if (!cor_q) begin
					if (mdn) begin
						if (k_q < 4'd9) jac_q[k_q] <= my;
						else f0_q[2'(k_q - 4'd9)] <= my;
						if (k_q == 4'd11) begin
							k_q <= '0;
							if (r_q != '0) begin
								cor_q <= 1'b1;
								mst <= 1'b1;
							end else begin
								f_q <= {my, f0_q[1], f0_q[0]};
								st_q <= S_EMIT;
							end
						end else begin
							k_q <= k_q + 4'd1;
							mst <= 1'b1;
						end
					end
				end else if (mdn) begin
					jac_q[k_q] <= sat_add(jac_q[k_q], my);
					if (k_q == 4'd8) begin
						f_q <= f0_q;
						st_q <= S_EMIT;
					end else begin
						k_q <= k_q + 4'd1;
						mst <= 1'b1;
					end
				end
				S_EMIT: if (!out_ch.valid || out_ch.ready) begin
					out_ch.valid <= 1'b1;
					out_ch.row <= row_q;
					out_ch.ok <= !zero_q;
					if (zero_q) begin
						out_ch.force_res <= '0;
						out_ch.jac_col0 <= '0;
						out_ch.jac_col1 <= '0;
						out_ch.jac_col2 <= '0;
						out_ch.last <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						out_ch.force_res <= pk(f_q[row_q]);
						out_ch.jac_col0 <= pk(jac_q[jrow_base]);
						out_ch.jac_col1 <= pk(jac_q[jrow_base + 4'd1]);
						out_ch.jac_col2 <= pk(jac_q[jrow_base + 4'd2]);
						out_ch.last <= row_q == 2'd2;
						row_q <= row_q + 2'd1;
						if (row_q == 2'd2) st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: sv/velocity_penalty_force_unit.sv
// Top level: velocity penalty force unit, force and Jacobian rows from one input beat.
//
// Use: an input beat carries velocity, penalty normal and base velocity (Q format).
// Each accepted beat yields three result beats, rows 0..2, last set on row 2, each
// with one force component and one Jacobian row. A zero normal gives a single
// beat with ok low and zero data.
// The front takes beats into a two-entry job queue while the back works; the
// back sequences a shared multiplier, a bit-serial divider and a two-bits-a-step
// root unit. Rows 1 and 2 follow row 0 in order. The three unit-vector divides
// (six with quadratic scaling) take most of the time of each beat.
// A stalled receiver holds the output register; the back waits, the queue fills,
// and then in ready drops. Reset clears the queue, the sequencer and the
// scaling mode register (to 0). Write the register only while idle.
`default_nettype none
module velocity_penalty_force_unit #(
	parameter int FRAC_BITS  = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	vpf_in_if.sink    in_ch,
	vpf_out_if.source out_ch,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata
);
	import vpf_pkg::*;
	logic quad_q;
	logic job_valid, job_pop;
	vpf_job_t job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) quad_q <= 1'b0;
		else if (cfg_we) quad_q <= cfg_wdata;
	end

	vpf_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (.clk, .arst_n, .in_ch, .quad(quad_q),
		.job_valid, .job_pop, .job);
	vpf_back #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_back (.clk, .arst_n,
		.job_valid, .job_pop, .job, .out_ch);

	// a result beat never names a row beyond two
	a_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.row != 2'd3) else $error("row out of range");
	// a failed beat is always the only one of its input
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ok) |-> (out_ch.last && out_ch.row == 2'd0))
		else $error("zero normal beat malformed");
	// last only on row two for good results
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ok) |-> (out_ch.last == (out_ch.row == 2'd2)))
		else $error("last misplaced");
endmodule
`default_nettype wire

FILE: sim/vpf_check.sv
// Checker: watches both channels, predicts the rows of each input beat and compares them.
`timescale 1ns / 100ps
`default_nettype none
module vpf_check (
	input  wire logic clk,
	input  wire logic arst_n,
	vpf_in_if         in_ch,
	vpf_out_if        out_ch,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	output int        fail_count,
	output int        rows_pending
);
	import vpf_pkg::*;

	typedef logic signed [63:0] s64_t;

	typedef struct {
		logic [1:0]         row;
		logic signed [31:0] frc;
		logic signed [31:0] jc [3];
		logic               ok;
		logic               last;
	} row_t;

	row_t row_q [$];
	logic quad_mode;

	function automatic logic [63:0] abs64(input s64_t x);
		logic [63:0] u;
		u = x;
		return x[63] ? (~u + 64'd1) : u;
	endfunction

	function automatic s64_t signed_of(input logic neg, input logic [127:0] m);
		if (neg)
			return (m >= (128'd1 << 63)) ? Q_MIN : -$signed(m[63:0]);
		return (m >= (128'd1 << 63)) ? Q_MAX : $signed(m[63:0]);
	endfunction

	function automatic s64_t add_sat(input s64_t a, input s64_t b);
		logic signed [64:0] t;
		t = {a[63], a} + {b[63], b};
		if (t[64] != t[63])
			return t[64] ? Q_MIN : Q_MAX;
		return t[63:0];
	endfunction

	function automatic s64_t neg_sat(input s64_t a);
		return (a == Q_MIN) ? Q_MAX : -a;
	endfunction

	// product rounded half away from zero at the binary point
	function automatic s64_t fx_mul(input s64_t a, input s64_t b);
		logic [127:0] p;
		p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
		p = p + (128'd1 << 15);
		return signed_of(a[63] ^ b[63], p >> 16);
	endfunction

	// a / d with d positive, rounded half away from zero
	function automatic s64_t fx_div(input s64_t a, input logic [63:0] d);
		logic [127:0] num, quo, rem, dd;
		num = {64'd0, abs64(a)} << 16;
		dd  = {64'd0, d};
		quo = num / dd;
		rem = num % dd;
		if (rem >= dd - rem)
			quo = quo + 128'd1;
		return signed_of(a[63], quo);
	endfunction

	function automatic logic [63:0] root_len(input logic [127:0] x);
		logic [63:0]  r, c;
		logic [127:0] sq;
		r = '0;
		for (int k = 63; k >= 0; k--) begin
			c  = r | (64'd1 << k);
			sq = {64'd0, c} * {64'd0, c};
			if (sq <= x)
				r = c;
		end
		if (r[63])
			r = 64'h7fff_ffff_ffff_ffff;
		return r;
	endfunction

	function automatic logic signed [31:0] clip32(input s64_t x);
		if (x > 64'sd2147483647)
			return 32'sh7fff_ffff;
		if (x < -64'sd2147483648)
			return 32'sh8000_0000;
		return x[31:0];
	endfunction

	task automatic predict_rows(input s64_t vel [3], input s64_t nrm [3], input s64_t bas [3]);
		s64_t rel [3];
		s64_t u [3];
		s64_t f [3];
		s64_t jac [3][3];
		s64_t ru [3];
		s64_t dot;
		logic [127:0] acc;
		logic [63:0] nlen, rlen;
		row_t r;
		acc = '0;
		dot = '0;
		for (int i = 0; i < 3; i++) begin
			rel[i] = vel[i] - bas[i];	// 32-bit operands, no overflow at 64 bits
			acc = acc + {64'd0, abs64(nrm[i])} * {64'd0, abs64(nrm[i])};
		end
		nlen = root_len(acc);
		if (nlen == 0) begin
			// zero normal: single flagged row
			r.row = 2'd0;
			r.frc = '0;
			r.jc[0] = '0; r.jc[1] = '0; r.jc[2] = '0;
			r.ok = 1'b0;
			r.last = 1'b1;
			row_q = {row_q, r};
			return;
		end
		for (int i = 0; i < 3; i++)
			dot = add_sat(dot, fx_mul(rel[i], nrm[i]));
		for (int i = 0; i < 3; i++) begin
			u[i] = fx_div(nrm[i], nlen);
			f[i] = neg_sat(fx_mul(dot, u[i]));
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				jac[i][j] = neg_sat(fx_mul(nrm[j], u[i]));
		if (quad_mode) begin
			acc = '0;
			for (int i = 0; i < 3; i++)
				acc = acc + {64'd0, abs64(rel[i])} * {64'd0, abs64(rel[i])};
			rlen = root_len(acc);
			for (int j = 0; j < 3; j++)
				ru[j] = (rlen != 0) ? fx_div(rel[j], rlen) : '0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					jac[i][j] = fx_mul(jac[i][j], $signed(rlen));
					if (rlen != 0)
						jac[i][j] = add_sat(jac[i][j], fx_mul(f[i], ru[j]));
				end
			for (int i = 0; i < 3; i++)
				f[i] = fx_mul(f[i], $signed(rlen));
		end
		for (int i = 0; i < 3; i++) begin
			r.row = i[1:0];
			r.frc = clip32(f[i]);
			for (int j = 0; j < 3; j++)
				r.jc[j] = clip32(jac[i][j]);
			r.ok = 1'b1;
			r.last = (i == 2);
			row_q = {row_q, r};
		end
	endtask

	task automatic cmp_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		rows_pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		s64_t v [3];
		s64_t n [3];
		s64_t b [3];
		row_t e;
		if (!arst_n) begin
			quad_mode = 1'b0;
		end else begin
			if (cfg_we)
				quad_mode = cfg_wdata;
			if (out_ch.valid && out_ch.ready) begin
				if (row_q.size() == 0) begin
					$error("result beat with no row expected");
					fail_count++;
				end else begin
					e = row_q.pop_front();
					cmp_field("row", {30'd0, e.row}, {30'd0, out_ch.row});
					cmp_field("force_res", e.frc, out_ch.force_res);
					cmp_field("jac_col0", e.jc[0], out_ch.jac_col0);
					cmp_field("jac_col1", e.jc[1], out_ch.jac_col1);
					cmp_field("jac_col2", e.jc[2], out_ch.jac_col2);
					cmp_field("ok", {31'd0, e.ok}, {31'd0, out_ch.ok});
					cmp_field("last", {31'd0, e.last}, {31'd0, out_ch.last});
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				v[0] = in_ch.vel_x;    v[1] = in_ch.vel_y;    v[2] = in_ch.vel_z;
				n[0] = in_ch.normal_x; n[1] = in_ch.normal_y; n[2] = in_ch.normal_z;
				b[0] = in_ch.base_x;   b[1] = in_ch.base_y;   b[2] = in_ch.base_z;
				predict_rows(v, n, b);
			end
		end
		rows_pending = row_q.size();
	end
endmodule
`default_nettype wire

FILE: sim/velocity_penalty_force_unit_tb.sv
// Testbench top: clock, reset, stimulus and verdict for the velocity penalty force unit.
`timescale 1ns / 100ps
`default_nettype none
module velocity_penalty_force_unit_tb;
	// beat layout: vel x/y/z, normal x/y/z, base x/y/z
	typedef logic [31:0] beat_t [9];

	localparam int IDLE_LIMIT = 60000;	// room for slow scaled beats plus receiver stalls
	localparam int N_RANDOM   = 200;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   fail_count;
	int   rows_pending;

	vpf_in_if  #(.DATA_WIDTH(32)) in_bus ();
	vpf_out_if #(.DATA_WIDTH(32)) out_bus ();

	velocity_penalty_force_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_bus),
		.out_ch   (out_bus),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	vpf_check checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_bus),
		.out_ch      (out_bus),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.rows_pending(rows_pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Receiver: its own stall pattern, with a mode drawn at random among three.
	int rx_mode;
	int rx_stall;
	int rx_tick;
	initial begin
		out_bus.ready = 1'b0;
		rx_mode = 0;
		rx_stall = 0;
		rx_tick = 0;
	end
	always @(negedge clk) begin
		rx_tick++;
		if (rx_tick % 64 == 0)
			rx_mode = $urandom_range(0, 2);
		if (rx_stall > 0) begin
			rx_stall--;
			out_bus.ready = 1'b0;
		end else begin
			case (rx_mode)
				0: begin
					out_bus.ready = 1'b1;
				end
				1: begin
					out_bus.ready = $urandom % 2;
				end
				default: begin
					if ($urandom % 8 == 0) begin
						rx_stall = $urandom_range(1, 30);
						out_bus.ready = 1'b0;
					end else begin
						out_bus.ready = 1'b1;
					end
				end
			endcase
		end
	end

	// Watchdog: cycles with no beat on either channel.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("velocity_penalty_force_unit: mismatch");
			$finish;
		end
	end

	// Sender state: bursts of random length with random gaps, gaps can be switched off.
	bit gaps_on;
	int burst_left;

	task automatic send_beat(input beat_t b);
		if (gaps_on && burst_left == 0) begin
			in_bus.valid = 1'b0;
			repeat ($urandom_range(1, 25)) @(negedge clk);
			burst_left = $urandom_range(1, 8);
		end
		{in_bus.vel_x, in_bus.vel_y, in_bus.vel_z} = {b[0], b[1], b[2]};
		{in_bus.normal_x, in_bus.normal_y, in_bus.normal_z} = {b[3], b[4], b[5]};
		{in_bus.base_x, in_bus.base_y, in_bus.base_z} = {b[6], b[7], b[8]};
		in_bus.valid = 1'b1;
		@(posedge clk);
		while (!in_bus.ready)
			@(posedge clk);
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
	endtask

	// Hold off until every expected row is back; the block is then idle.
	task automatic wait_drained();
		in_bus.valid = 1'b0;
		while (rows_pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_quad(input logic val);
		wait_drained();
		cfg_we = 1'b1;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Word mix: full random, small magnitudes, extremes, zero.
	function automatic logic [31:0] pick_word();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 4)
			return $urandom;
		if (kind < 8)
			return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		if (kind == 8)
			case ($urandom_range(0, 4))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'h0000_0001;
				3: return 32'hffff_ffff;
				default: return 32'h0001_0000;
			endcase
		return 32'd0;
	endfunction

	task automatic send_random();
		beat_t b;
		for (int k = 0; k < 9; k++)
			b[k] = pick_word();
		if ($urandom % 12 == 0)
			{b[3], b[4], b[5]} = '0;	// zero normal
		if ($urandom % 10 == 0)
			{b[6], b[7], b[8]} = {b[0], b[1], b[2]};	// zero relative velocity
		send_beat(b);
	endtask

	task automatic run_directed();
		beat_t b;
		// all zero: zero normal
		b = '{default: 32'd0};
		send_beat(b);
		// zero normal with motion
		b = '{32'h0002_0000, 32'hfffd_0000, 32'h0000_8000, 0, 0, 0, 32'h0001_0000, 0, 0};
		send_beat(b);
		// unit normal along x
		b = '{32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 0, 0, 0, 0, 0};
		send_beat(b);
		// oblique normal, base moving
		b = '{32'h0001_8000, 32'hffff_0000, 32'h0000_4000, 32'h0003_0000, 32'h0004_0000, 0,
			32'h0000_8000, 32'h0000_2000, 32'hfffe_0000};
		send_beat(b);
		// relative velocity zero
		b = '{32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0000_1000, 32'h0002_0000,
			32'hffff_0000, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000};
		send_beat(b);
		// one-lsb normal
		b = '{32'h0001_0000, 0, 0, 0, 0, 32'h0000_0001, 0, 0, 0};
		send_beat(b);
		// everything at the positive limit
		b = '{default: 32'h7fff_ffff};
		send_beat(b);
		// everything at the negative limit
		b = '{default: 32'h8000_0000};
		send_beat(b);
		// widest relative velocity, saturating results
		b = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
		send_beat(b);
		// tiny relative speed against a big normal
		b = '{32'h0000_0001, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0, 0};
		send_beat(b);
		// all ones
		b = '{default: 32'hffff_ffff};
		send_beat(b);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_bus.valid = 1'b0;
		{in_bus.vel_x, in_bus.vel_y, in_bus.vel_z} = '0;
		{in_bus.normal_x, in_bus.normal_y, in_bus.normal_z} = '0;
		{in_bus.base_x, in_bus.base_y, in_bus.base_z} = '0;
		gaps_on = 1'b0;
		burst_left = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, both settings, back to back then with gaps
		write_quad(1'b0);
		run_directed();
		write_quad(1'b1);
		gaps_on = 1'b1;
		run_directed();

		// random phases, setting toggled between them
		for (int p = 0; p < 4; p++) begin
			write_quad(p[0]);
			gaps_on = (p != 2);
			for (int k = 0; k < N_RANDOM / 4; k++)
				send_random();
		end

		wait_drained();
		repeat (700) @(negedge clk);
		if (fail_count == 0)
			$display("velocity_penalty_force_unit: match");
		else
			$display("velocity_penalty_force_unit: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
sv/vpf_pkg.sv
sv/vpf_if.sv
sv/vpf_mul.sv
sv/vpf_sqrt.sv
sv/vpf_div.sv
sv/vpf_front.sv
sv/vpf_back.sv
sv/velocity_penalty_force_unit.sv
sim/vpf_check.sv
sim/velocity_penalty_force_unit_tb.sv
